### src/pli_pkg.sv
package pli_pkg;

  localparam int SampleBits    = 16;
  localparam int IdxBits       = 8;
  localparam int ChanBits      = 8;
  localparam int FracBits      = 8;
  localparam int GainBits      = 32;
  localparam int CfgIdxBits    = 2;
  localparam int CfgDataBits   = 32;
  localparam int DefTableDepth = 256;

  localparam logic signed [SampleBits-1:0] LowValueRst  = '0;
  localparam logic [GainBits-1:0]          SpanGainRst  = 32'd65536;
  localparam logic [IdxBits-1:0]           LastEntryRst = 8'd255;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LOW_VALUE  = 2'd0,
    CFG_SPAN_GAIN  = 2'd1,
    CFG_LAST_ENTRY = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_CONVERT = 1'b0,
    MODE_LOAD    = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                         mode;
    logic signed [SampleBits-1:0]  sample;
    logic [IdxBits-1:0]            entry_index;
    logic [ChanBits-1:0]           entry_red;
    logic [ChanBits-1:0]           entry_green;
    logic [ChanBits-1:0]           entry_blue;
  } in_word_t;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
  } color_t;

  typedef struct packed {
    logic               wr_en;
    logic [IdxBits-1:0] wr_idx;
    color_t             wr_data;
    logic               rd_en;
    logic [IdxBits-1:0] rd_idx_a;
    logic [IdxBits-1:0] rd_idx_b;
  } tbl_req_t;

endpackage

### src/pli_table.sv
module pli_table #(
  parameter int TableDepth = pli_pkg::DefTableDepth
) (
  input  logic              clk_i,
  input  pli_pkg::tbl_req_t req_i,
  output pli_pkg::color_t   rd_a_o,
  output pli_pkg::color_t   rd_b_o
);

  localparam int AddrBits = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  pli_pkg::color_t mem [TableDepth];
  pli_pkg::color_t rd_a_q;
  pli_pkg::color_t rd_b_q;

  // Reads beyond the table land on its last entry.
  function automatic logic [AddrBits-1:0] rd_addr(input logic [pli_pkg::IdxBits-1:0] idx);
    if (int'(idx) >= TableDepth) begin
      return AddrBits'(TableDepth - 1);
    end
    return AddrBits'(idx);
  endfunction

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && (int'(req_i.wr_idx) < TableDepth)) begin
      mem[AddrBits'(req_i.wr_idx)] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_a_q <= mem[rd_addr(req_i.rd_idx_a)];
      rd_b_q <= mem[rd_addr(req_i.rd_idx_b)];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### src/pli_blend.sv
module pli_blend (
  input  pli_pkg::color_t                  a_i,
  input  pli_pkg::color_t                  b_i,
  input  logic [pli_pkg::FracBits-1:0]     frac_i,
  output pli_pkg::color_t                  mix_o
);

  localparam int MulBits = pli_pkg::ChanBits + pli_pkg::FracBits + 1;

  // Weighted sum a*(256-f) + b*f, keeping the integer part.
  function automatic logic [pli_pkg::ChanBits-1:0] mix(
    input logic [pli_pkg::ChanBits-1:0] a,
    input logic [pli_pkg::ChanBits-1:0] b,
    input logic [pli_pkg::FracBits-1:0] f
  );
    logic [pli_pkg::FracBits:0] wa;
    logic [MulBits-1:0]         acc;
    wa  = {1'b1, {pli_pkg::FracBits{1'b0}}} - {1'b0, f};
    acc = (MulBits'(a) * MulBits'(wa)) + (MulBits'(b) * MulBits'(f));
    return acc[pli_pkg::ChanBits+pli_pkg::FracBits-1:pli_pkg::FracBits];
  endfunction

  always_comb begin
    mix_o.red   = mix(a_i.red,   b_i.red,   frac_i);
    mix_o.green = mix(a_i.green, b_i.green, frac_i);
    mix_o.blue  = mix(a_i.blue,  b_i.blue,  frac_i);
  end

endmodule

### src/pseudocolor_lut_interpolator_unit.sv
// Colour lookup with linear interpolation. A convert word takes a signed sample, scales it
// against low_value and span_gain into a Q.8 table position, reads the two neighbouring
// entries of the colour table and blends them; the coloured word passes stage 1, stage 2,
// table read and output registers. A load word writes one table entry and produces no
// output. One word of either kind is accepted every clock unless stalled: the table has one
// write port and two read ports, and loads write it at the same stage where lookups read
// it, so a lookup sees exactly the loads that were accepted before it. Stall from the output
// only holds the words that have nowhere to go; empty stages keep filling. The table is not
// cleared at reset, so every entry a lookup may touch must be loaded first. Configuration
// writes are taken at any time but must only be made while no word is in flight.
module pseudocolor_lut_interpolator_unit #(
  parameter int TableDepth = pli_pkg::DefTableDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pli_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pli_pkg::color_t                    out_word_o,
  input  logic                               cfg_we_i,
  input  logic [pli_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [pli_pkg::CfgDataBits-1:0]    cfg_wdata_i
);

  localparam int SB       = pli_pkg::SampleBits;
  localparam int Half     = pli_pkg::GainBits / 2;
  localparam int ProdBits = SB + Half;
  localparam int SumBits  = ProdBits + 1;
  localparam int PosBits  = pli_pkg::IdxBits + pli_pkg::FracBits;

  // Configuration registers.
  logic signed [SB-1:0]                low_value_q;
  logic [pli_pkg::GainBits-1:0]        span_gain_q;
  logic [pli_pkg::IdxBits-1:0]         last_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_value_q  <= pli_pkg::LowValueRst;
      span_gain_q  <= pli_pkg::SpanGainRst;
      last_entry_q <= pli_pkg::LastEntryRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pli_pkg::CFG_LOW_VALUE:  low_value_q  <= cfg_wdata_i[SB-1:0];
        pli_pkg::CFG_SPAN_GAIN:  span_gain_q  <= cfg_wdata_i[pli_pkg::GainBits-1:0];
        pli_pkg::CFG_LAST_ENTRY: last_entry_q <= cfg_wdata_i[pli_pkg::IdxBits-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage may load when it is empty or its word moves on.
  logic v1_q, v2_q, v3_q, vo_q;
  logic go1, go2, go3, go_out;
  logic in_acc;

  assign go_out     = !vo_q || !out_stall_i;
  assign go3        = !v3_q || go_out;
  assign go2        = !v2_q || go3;
  assign go1        = !v1_q || go2;
  assign in_stall_o = !go1;
  assign in_acc     = in_valid_i && go1;

  // Stage 1: positive part of the sample offset.
  logic [SB:0]                 diff;
  logic [SB-1:0]               mag_d;
  logic [SB-1:0]               mag1_q;
  pli_pkg::mode_e              mode1_q;
  logic [pli_pkg::IdxBits-1:0] widx1_q;
  pli_pkg::color_t             wcol1_q;

  always_comb begin
    diff  = {in_word_i.sample[SB-1], in_word_i.sample} - {low_value_q[SB-1], low_value_q};
    mag_d = (!diff[SB] && (|diff)) ? diff[SB-1:0] : '0;
  end

  // Stage 2: gain product as two half-width partial products.
  logic [ProdBits-1:0]         plo_q;
  logic [ProdBits-1:0]         phi_q;
  pli_pkg::mode_e              mode2_q;
  logic [pli_pkg::IdxBits-1:0] widx2_q;
  pli_pkg::color_t             wcol2_q;

  // Stage 3: table data sits in the table's read registers.
  logic [pli_pkg::FracBits-1:0] frac3_q;

  pli_pkg::color_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (go1) begin
        v1_q <= in_valid_i;
      end
      if (go2) begin
        v2_q <= v1_q;
      end
      if (go3) begin
        v3_q <= v2_q && (mode2_q == pli_pkg::MODE_CONVERT);
      end
      if (go_out) begin
        vo_q <= v3_q;
      end
    end
  end

  // Table position, clamp and neighbour selection.
  logic [SumBits-1:0]           pos_full;
  logic [PosBits-1:0]           limit;
  logic [PosBits-1:0]           pos_d;
  logic [pli_pkg::IdxBits-1:0]  idx_a;
  logic [pli_pkg::IdxBits-1:0]  idx_b;
  logic [pli_pkg::FracBits-1:0] frac_d;

  always_comb begin
    pos_full = SumBits'(phi_q) + SumBits'(plo_q >> Half);
    limit    = {last_entry_q, {pli_pkg::FracBits{1'b0}}};
    pos_d    = (pos_full > SumBits'(limit)) ? limit : pos_full[PosBits-1:0];
    idx_a    = pos_d[PosBits-1:pli_pkg::FracBits];
    frac_d   = pos_d[pli_pkg::FracBits-1:0];
    idx_b    = (idx_a == last_entry_q) ? idx_a : idx_a + pli_pkg::IdxBits'(1);
  end

  pli_pkg::color_t mix_d;
  pli_pkg::color_t rd_a;
  pli_pkg::color_t rd_b;
  pli_pkg::tbl_req_t tbl_req;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode1_q <= in_word_i.mode;
      mag1_q  <= mag_d;
      widx1_q <= in_word_i.entry_index;
      wcol1_q <= '{red:   in_word_i.entry_red,
                   green: in_word_i.entry_green,
                   blue:  in_word_i.entry_blue};
    end
    if (go2 && v1_q) begin
      mode2_q <= mode1_q;
      plo_q   <= ProdBits'(mag1_q) * ProdBits'(span_gain_q[Half-1:0]);
      phi_q   <= ProdBits'(mag1_q) * ProdBits'(span_gain_q[pli_pkg::GainBits-1:Half]);
      widx2_q <= widx1_q;
      wcol2_q <= wcol1_q;
    end
    if (go3 && v2_q) begin
      frac3_q <= frac_d;
    end
    if (go_out && v3_q) begin
      out_word_q <= mix_d;
    end
  end

  always_comb begin
    tbl_req.wr_en    = v2_q && go3 && (mode2_q == pli_pkg::MODE_LOAD);
    tbl_req.wr_idx   = widx2_q;
    tbl_req.wr_data  = wcol2_q;
    tbl_req.rd_en    = v2_q && go3 && (mode2_q == pli_pkg::MODE_CONVERT);
    tbl_req.rd_idx_a = idx_a;
    tbl_req.rd_idx_b = idx_b;
  end

  pli_table #(
    .TableDepth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .req_i  (tbl_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  pli_blend u_blend (
    .a_i    (rd_a),
    .b_i    (rd_b),
    .frac_i (frac3_q),
    .mix_o  (mix_d)
  );

  assign out_valid_o = vo_q;
  assign out_word_o  = out_word_q;

endmodule

### src/pli_checker.sv
module pli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input pli_pkg::in_word_t in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pli_pkg::color_t   out_word_o
);

  // A word held at the output keeps its colour.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // The input is held back only when the whole pipe is blocked by the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output is free");

  // With the output free, a converted sample shows at the output once it has passed every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.mode == pli_pkg::MODE_CONVERT) && !out_stall_i)
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("converted sample did not arrive on time");

endmodule

bind pseudocolor_lut_interpolator_unit pli_checker u_pli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
